[rtl/alphabet_word_index_codec_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the alphabet word index codec
// Concurrent assertions that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ALPHABET_WORD_INDEX_CODEC_ASSERT_SVH
`define ALPHABET_WORD_INDEX_CODEC_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on each rising edge, ignored while reset is low
`define AWIC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Implication checked on each rising edge, ignored while reset is low
`define AWIC_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: assertion failed");
`else
`define AWIC_ASSERT(label, clk, rst_n, prop)
`define AWIC_ASSERT_IMP(label, clk, rst_n, cond, prop)
`endif

`endif

[rtl/awic_pkg.sv]
// ----------------------------------------------------------------------------
// awic_pkg
// Types, constants and codes shared by the alphabet word index codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awic_pkg;

    // Field widths
    localparam int SYM_W   = 8;
    localparam int DIG_W   = 6;
    localparam int CODE_W  = 64;
    localparam int RADIX_W = 7;
    localparam int LEN_W   = 7;
    localparam int NSYM    = 1 << SYM_W;
    localparam int NDIG    = 1 << DIG_W;

    // Stream widths
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 80;

    // Parameter defaults
    localparam int ALPHABET_MAX_DEF = 64;
    localparam int MAX_WORD_LEN_DEF = 64;

    // Configuration registers
    localparam logic CFG_ALPHABET_SIZE = 1'b0;
    localparam logic CFG_WORD_LENGTH   = 1'b1;
    localparam logic [RADIX_W-1:0] ALPHABET_SIZE_RST = 7'd2;
    localparam logic [LEN_W-1:0]   WORD_LENGTH_RST   = 7'd8;
    localparam logic [RADIX_W-1:0] RADIX_MIN         = 7'd2;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Division: quotient bits retired per cycle, cycles per digit
    localparam int DIV_STEPS = 8;
    localparam int DIV_CYC   = CODE_W / DIV_STEPS;
    localparam int DCNT_W    = $clog2(DIV_CYC);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_DECODE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // Classified command handed from front to back
    typedef struct packed {
        t_op               op;
        logic [SYM_W-1:0]  sym;
        logic [DIG_W-1:0]  digit;
        t_status           status;
        logic              last;
        logic [CODE_W-1:0] code;
    } t_cmd;

    // One result transaction
    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic              last;
        t_status           status;
    } t_result;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_LOAD,
        BS_ENC_MUL,
        BS_ENC_ADD,
        BS_DEC_START,
        BS_DIV,
        BS_RD,
        BS_EMIT
    } t_bstate;

endpackage

[rtl/awic_front.sv]
// ----------------------------------------------------------------------------
// awic_front
// Accepts items, keeps the symbol tables and classifies each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awic_front
    import awic_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_op                i_op,
    input  logic [SYM_W-1:0]   i_sym,
    input  logic [DIG_W-1:0]   i_pos,
    input  logic [CODE_W-1:0]  i_code,
    input  logic               i_last,
    input  logic [RADIX_W-1:0] i_radix,
    output logic               o_push,
    output t_cmd               o_cmd,
    input  logic               i_full
);

    logic [NSYM-1:0]  r_seen;
    logic [DIG_W-1:0] r_dig_mem [NSYM];
    logic [DIG_W-1:0] r_dig_rd;
    logic             r_valid;
    t_cmd             r_cmd;

    logic             accept;
    logic             hit;
    logic             load_ok;
    t_status          status;

    assign accept = i_valid && o_ready;
    assign o_push = r_valid && !i_full;
    assign o_ready = !r_valid || o_push;
    assign hit = r_seen[i_sym];

    // Classify the incoming item
    always_comb begin
        load_ok = 1'b0;
        status  = ST_OK;
        unique case (i_op)
            OP_LOAD: begin
                if ({1'b0, i_pos} >= i_radix) begin
                    status = ST_RANGE;
                end else if (hit) begin
                    status = ST_DUP;
                end else begin
                    load_ok = 1'b1;
                end
            end
            OP_ENCODE: begin
                status = hit ? ST_OK : ST_UNKNOWN;
            end
            OP_DECODE, OP_CLEAR: begin
                status = ST_OK;
            end
        endcase
    end

    // Symbol loaded flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (accept) begin
            if (i_op == OP_CLEAR) begin
                r_seen <= '0;
            end else if (load_ok) begin
                r_seen[i_sym] <= 1'b1;
            end
        end
    end

    // Digit of each symbol
    always_ff @(posedge i_clk) begin
        if (accept && load_ok) begin
            r_dig_mem[i_sym] <= i_pos;
        end
        if (accept) begin
            r_dig_rd <= r_dig_mem[i_sym];
        end
    end

    // Holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= (i_op != OP_CLEAR);
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op     <= i_op;
            r_cmd.sym    <= i_sym;
            r_cmd.digit  <= i_pos;
            r_cmd.status <= status;
            r_cmd.last   <= i_last;
            r_cmd.code   <= i_code;
        end
    end

    // Encode items take the looked-up digit
    always_comb begin
        o_cmd = r_cmd;
        if (r_cmd.op == OP_ENCODE) begin
            o_cmd.digit = r_dig_rd;
        end
    end

endmodule

[rtl/awic_queue.sv]
// ----------------------------------------------------------------------------
// awic_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "alphabet_word_index_codec_assert.svh"

module awic_queue
    import awic_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    `AWIC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `AWIC_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)
    `AWIC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH))

endmodule

[rtl/awic_back.sv]
// ----------------------------------------------------------------------------
// awic_back
// Carries out commands: table writes, index accumulation, digit extraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "alphabet_word_index_codec_assert.svh"

module awic_back
    import awic_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [RADIX_W-1:0] i_radix,
    input  logic [LEN_W-1:0]   i_target,
    input  logic               i_q_valid,
    input  t_cmd               i_q_head,
    output logic               o_pop,
    output logic               o_res_valid,
    output t_result            o_res,
    input  logic               i_res_ready
);

    t_bstate           r_state, n_state;
    t_cmd              r_cmd;
    logic [CODE_W-1:0] r_code, n_code;
    logic [CODE_W-1:0] r_power, n_power;
    logic              r_werr, n_werr;
    logic [CODE_W-1:0] r_prod, n_prod;
    logic [CODE_W-1:0] r_dq, n_dq;
    logic [DIG_W-1:0]  r_rem, n_rem;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic [LEN_W-1:0]  r_n, n_n;
    logic              r_pad, n_pad;
    logic              r_ov, n_ov;
    t_result           r_res, n_res;

    logic [SYM_W-1:0]  r_sym_mem [NDIG];
    logic [SYM_W-1:0]  r_sym_rd;
    logic              mem_we;
    logic [DIG_W-1:0]  rd_addr;

    logic              out_free;
    logic [CODE_W-1:0] enc_sum;
    logic [RADIX_W:0]  div_rem;
    logic [CODE_W-1:0] div_dq;
    logic              dec_last;

    assign out_free    = !r_ov || i_res_ready;
    assign o_res_valid = r_ov;
    assign o_res       = r_res;
    assign o_pop       = (r_state == BS_IDLE) && i_q_valid;
    assign enc_sum     = r_code + r_prod;
    assign rd_addr     = r_pad ? '0 : r_rem;
    assign dec_last    = (r_pad || (r_dq == '0)) && ((r_n + 1'b1) >= i_target);

    // Eight restoring division steps per cycle
    always_comb begin
        div_rem = {2'b00, r_rem};
        div_dq  = r_dq;
        for (int i = 0; i < DIV_STEPS; i++) begin
            div_rem = {div_rem[RADIX_W-1:0], div_dq[CODE_W-1]};
            div_dq  = {div_dq[CODE_W-2:0], 1'b0};
            if (div_rem >= {1'b0, i_radix}) begin
                div_rem   = div_rem - {1'b0, i_radix};
                div_dq[0] = 1'b1;
            end
        end
    end

    // Next state and datapath
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_power = r_power;
        n_werr  = r_werr;
        n_prod  = r_prod;
        n_dq    = r_dq;
        n_rem   = r_rem;
        n_dcnt  = r_dcnt;
        n_n     = r_n;
        n_pad   = r_pad;
        n_ov    = r_ov && !i_res_ready;
        n_res   = r_res;
        mem_we  = 1'b0;

        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_head.op)
                        OP_LOAD:   n_state = BS_LOAD;
                        OP_ENCODE: n_state = BS_ENC_MUL;
                        OP_DECODE: n_state = BS_DEC_START;
                        OP_CLEAR:  n_state = BS_IDLE;
                    endcase
                end
            end
            BS_LOAD: begin
                if (out_free) begin
                    mem_we       = (r_cmd.status == ST_OK);
                    n_ov         = 1'b1;
                    n_res.sym    = r_cmd.sym;
                    n_res.code   = '0;
                    n_res.last   = 1'b1;
                    n_res.status = r_cmd.status;
                    n_state      = BS_IDLE;
                end
            end
            BS_ENC_MUL: begin
                n_prod  = (r_cmd.status == ST_OK)
                        ? CODE_W'(r_power * {{(CODE_W-DIG_W){1'b0}}, r_cmd.digit}) : '0;
                n_power = CODE_W'(r_power * {{(CODE_W-RADIX_W){1'b0}}, i_radix});
                n_werr  = r_werr || (r_cmd.status == ST_UNKNOWN);
                n_state = BS_ENC_ADD;
            end
            BS_ENC_ADD: begin
                if (!r_cmd.last) begin
                    n_code  = enc_sum;
                    n_state = BS_IDLE;
                end else if (out_free) begin
                    n_ov         = 1'b1;
                    n_res.sym    = '0;
                    n_res.code   = enc_sum;
                    n_res.last   = 1'b1;
                    n_res.status = r_werr ? ST_UNKNOWN : ST_OK;
                    n_code       = '0;
                    n_power      = CODE_W'(1);
                    n_werr       = 1'b0;
                    n_state      = BS_IDLE;
                end
            end
            BS_DEC_START: begin
                n_dq   = r_cmd.code;
                n_rem  = '0;
                n_dcnt = '0;
                n_n    = '0;
                if (r_cmd.code != '0) begin
                    n_pad   = 1'b0;
                    n_state = BS_DIV;
                end else if (i_target != '0) begin
                    n_pad   = 1'b1;
                    n_state = BS_RD;
                end else begin
                    n_state = BS_IDLE;
                end
            end
            BS_DIV: begin
                n_dq   = div_dq;
                n_rem  = div_rem[DIG_W-1:0];
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DCNT_W'(DIV_CYC - 1)) begin
                    n_state = BS_RD;
                end
            end
            BS_RD: begin
                n_state = BS_EMIT;
            end
            BS_EMIT: begin
                if (out_free) begin
                    n_ov         = 1'b1;
                    n_res.sym    = r_sym_rd;
                    n_res.code   = '0;
                    n_res.last   = dec_last;
                    n_res.status = ST_OK;
                    n_n          = r_n + 1'b1;
                    if (dec_last) begin
                        n_state = BS_IDLE;
                    end else if (!r_pad && (r_dq != '0)) begin
                        n_rem   = '0;
                        n_dcnt  = '0;
                        n_state = BS_DIV;
                    end else begin
                        n_pad   = 1'b1;
                        n_state = BS_RD;
                    end
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_code  <= '0;
            r_power <= CODE_W'(1);
            r_werr  <= 1'b0;
            r_pad   <= 1'b0;
        end else begin
            r_ov    <= n_ov;
            r_code  <= n_code;
            r_power <= n_power;
            r_werr  <= n_werr;
            r_pad   <= n_pad;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_head;
        end
        r_prod <= n_prod;
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_dcnt <= n_dcnt;
        r_n    <= n_n;
        r_res  <= n_res;
    end

    // Symbol of each digit
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_sym_mem[r_cmd.digit] <= r_cmd.sym;
        end
        r_sym_rd <= r_sym_mem[rd_addr];
    end

    `AWIC_ASSERT_IMP(a_rem_below_radix, i_clk, i_rst_n, (r_state == BS_RD) && !r_pad,
        {1'b0, r_rem} < i_radix)
    `AWIC_ASSERT_IMP(a_digit_count, i_clk, i_rst_n, r_state == BS_EMIT,
        r_n < LEN_W'(NDIG))

endmodule

[rtl/alphabet_word_index_codec.sv]
// ----------------------------------------------------------------------------
// alphabet_word_index_codec
// Converts words over a loaded alphabet to and from their base-N index.
// ----------------------------------------------------------------------------
// Throughput: the front takes one item per cycle into a two-entry command
// queue while the queue has room; the back executes one command at a time.
// A load passes through issue, then table write and result; an encode symbol
// through issue, a multiply state and an add state. A load, or the last
// symbol of a word, leaves its result in the output register. A decode item
// extracts each digit with an eight-bit-per-cycle divider, then one symbol
// table read, then a result state, and each padding symbol with a table read
// and a result state. Clear items are handled in the front and never reach
// the queue. Results come from an output register, so a stalled sink holds
// the back, and the front only once the command queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alphabet_word_index_codec
    import awic_pkg::*;
#(
    parameter int ALPHABET_MAX = ALPHABET_MAX_DEF,
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // symbol, digit_position, code_value
    input  logic [1:0]          i_s_tuser,   // opcode
    input  logic                i_s_tlast,   // last_symbol
    // Result stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // symbol_out, code_out, status
    output logic                o_m_tlast,   // last_result
    // Configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [RADIX_W-1:0]  i_cfg_data
);

    localparam int RADIX_CAP = (ALPHABET_MAX < NDIG) ? ALPHABET_MAX : NDIG;

    logic [RADIX_W-1:0] r_alpha_size;
    logic [LEN_W-1:0]   r_word_len;
    logic [RADIX_W-1:0] radix;
    logic [LEN_W-1:0]   target;

    logic    push;
    t_cmd    fe_cmd;
    logic    q_full;
    logic    q_valid;
    t_cmd    q_head;
    logic    pop;
    logic    res_valid;
    t_result res;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_size <= ALPHABET_SIZE_RST;
            r_word_len   <= WORD_LENGTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ALPHABET_SIZE: r_alpha_size <= i_cfg_data;
                CFG_WORD_LENGTH:   r_word_len   <= i_cfg_data;
            endcase
        end
    end

    // Effective radix and padding length
    always_comb begin
        if (r_alpha_size < RADIX_MIN) begin
            radix = RADIX_MIN;
        end else if (r_alpha_size > RADIX_W'(RADIX_CAP)) begin
            radix = RADIX_W'(RADIX_CAP);
        end else begin
            radix = r_alpha_size;
        end
        target = (r_word_len > LEN_W'(MAX_WORD_LEN)) ? LEN_W'(MAX_WORD_LEN) : r_word_len;
    end

    awic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (t_op'(i_s_tuser)),
        .i_sym   (i_s_tdata[7:0]),
        .i_pos   (i_s_tdata[13:8]),
        .i_code  (i_s_tdata[77:14]),
        .i_last  (i_s_tlast),
        .i_radix (radix),
        .o_push  (push),
        .o_cmd   (fe_cmd),
        .i_full  (q_full)
    );

    awic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (fe_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (pop)
    );

    awic_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix     (radix),
        .i_target    (target),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (i_m_tready)
    );

    // Result packing
    assign o_m_tvalid = res_valid;
    assign o_m_tlast  = res.last;
    assign o_m_tdata  = {6'b0, res.status, res.code, res.sym};

endmodule
